// ----- hw/rtl/clac_pkg.sv -----
// ----------------------------------------------------------------------------
// clac_pkg
// Shared types, widths and constants of the collision lookahead check block.
// ----------------------------------------------------------------------------
package clac_pkg;

    // field widths
    localparam int POS_W = 32;
    localparam int HDG_W = 16;
    localparam int SPD_W = 32;
    localparam int RAD_W = 32;
    localparam int LA_W  = 10;

    // stream and register port widths
    localparam int S_DATA_W   = 272;
    localparam int M_DATA_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_LOOKAHEAD_DEF = 1024;

    // register map, index taken from paddr[2]
    localparam logic REG_OWN_RADIUS = 1'b0;
    localparam logic [RAD_W-1:0] OWN_RADIUS_RST = 32'd65536;

    // sine/cosine unit
    localparam int CS_W         = 18;
    localparam int ANG_W        = 20;
    localparam int ITER_W       = 4;
    localparam int CORDIC_ITERS = 16;
    localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 18'sd39797;
    localparam logic signed [ANG_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;

    // shared multiplier
    localparam int LIMB_W    = 32;
    localparam int MUL_W     = 2 * LIMB_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_STEPS = 4;

    // divide by 60 through a reciprocal, exact for dividends below 2**49
    localparam int DIV_SHIFT = 55;
    localparam logic [MUL_W-1:0] DIV60_RECIP = ((64'd1 << DIV_SHIFT) + 64'd59) / 64'd60;

    // datapath widths
    localparam int MID_W  = 49;
    localparam int QUO_W  = 44;
    localparam int DISP_W = 46;
    localparam int REL_W  = 50;
    localparam int MAGX_W = REL_W + 1;
    localparam int RSUM_W = 49;
    localparam int ACC_W  = 112;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_OWN,
        ST_ROT_OTHER,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_PREP_S,
        ST_PREP_R,
        ST_SCAN,
        ST_EMIT
    } clac_state_t;

    typedef enum logic [3:0] {
        OP_OWN_C,
        OP_OWN_CQ,
        OP_OWN_S,
        OP_OWN_SQ,
        OP_OTH_C,
        OP_OTH_CQ,
        OP_OTH_S,
        OP_OTH_SQ,
        OP_RAD,
        OP_XX,
        OP_YY,
        OP_XS,
        OP_YS,
        OP_SXX,
        OP_SYY
    } clac_op_t;

    typedef struct packed {
        logic                    start;
        logic signed [HDG_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [CS_W-1:0] cos_val;
        logic signed [CS_W-1:0] sin_val;
    } cordic_rsp_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            4'd15:   v = 20'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/clac_cordic.sv -----
// ----------------------------------------------------------------------------
// clac_cordic
// Iterative sine/cosine unit, one rotation per cycle, Q.16 results.
// ----------------------------------------------------------------------------
module clac_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  clac_pkg::cordic_req_t req,
    output clac_pkg::cordic_rsp_t rsp
);
    import clac_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [ITER_W-1:0]       i_reg;
    logic signed [CS_W-1:0]  x_reg;
    logic signed [CS_W-1:0]  y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [ANG_W-1:0] z_ext;
    logic signed [ANG_W-1:0] z_red;
    logic                    neg_red;
    logic signed [CS_W-1:0]  xs;
    logic signed [CS_W-1:0]  ys;
    logic signed [ANG_W-1:0] at;

    // angle widened to Q.16 and folded into the half plane around zero
    always_comb begin
        z_ext   = ANG_W'(req.angle) <<< 3;
        z_red   = z_ext;
        neg_red = 1'b0;
        if (z_ext > HALF_PI_Q16) begin
            z_red   = z_ext - PI_Q16;
            neg_red = 1'b1;
        end else if (z_ext < -HALF_PI_Q16) begin
            z_red   = z_ext + PI_Q16;
            neg_red = 1'b1;
        end
    end

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = atan_q16(i_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && i_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_red;
            neg_reg <= neg_red;
            i_reg   <= '0;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + ITER_W'(1);
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_val = neg_reg ? -x_reg : x_reg;
    assign rsp.sin_val = neg_reg ? -y_reg : y_reg;

endmodule

// ----- hw/rtl/clac_mul.sv -----
// ----------------------------------------------------------------------------
// clac_mul
// Shared unsigned 64 x 64 multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module clac_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  clac_pkg::mul_req_t req,
    output clac_pkg::mul_rsp_t rsp
);
    import clac_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [2:0]          idx_reg;
    logic [MUL_W-1:0]    a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [MUL_W-1:0]    pp_reg;
    logic [1:0]          pair_reg;
    logic [PROD_W-1:0]   acc_reg;

    logic [LIMB_W-1:0]   a_limb;
    logic [LIMB_W-1:0]   b_limb;
    logic [PROD_W-1:0]   pp_shift;
    logic                issue;

    always_comb begin
        a_limb = idx_reg[0] ? a_reg[MUL_W-1:LIMB_W] : a_reg[LIMB_W-1:0];
        b_limb = idx_reg[1] ? b_reg[MUL_W-1:LIMB_W] : b_reg[LIMB_W-1:0];
        issue  = busy_reg && (idx_reg < 3'(MUL_STEPS));
    end

    always_comb begin
        case (pair_reg)
            2'b00:        pp_shift = PROD_W'(pp_reg);
            2'b01, 2'b10: pp_shift = PROD_W'(pp_reg) << LIMB_W;
            2'b11:        pp_shift = PROD_W'(pp_reg) << (2 * LIMB_W);
            default:      pp_shift = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (busy_reg) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'(MUL_STEPS)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (issue) begin
                pp_reg   <= a_limb * b_limb;
                pair_reg <= idx_reg[1:0];
            end
            if (idx_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ----- hw/rtl/collision_lookahead_check.sv -----
// ----------------------------------------------------------------------------
// collision_lookahead_check
// Constant-velocity collision prediction for two discs over a step horizon.
// ----------------------------------------------------------------------------
// One query beat is taken while the block is idle and gives exactly one result
// beat. Setup runs two sine/cosine rotations, then fifteen products on the one
// shared 32 x 32 multiplier. The scan then checks one step per cycle, using
// running first and second differences of the squared distance, up to the first
// hit or to lookahead_steps. A finished result waits in the output register
// while the next query is taken. own_radius is written over APB at address 0.
// ----------------------------------------------------------------------------
module collision_lookahead_check #(
    parameter int MAX_LOOKAHEAD = clac_pkg::MAX_LOOKAHEAD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // own_pos_x, own_pos_y, own_heading, own_speed, other_pos_x, other_pos_y,
    // other_heading, other_speed, other_radius, lookahead_steps, zero pad
    input  logic [clac_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_found, hit_step, zero pad
    output logic [clac_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [clac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [clac_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import clac_pkg::*;

    localparam int LA_MAX  = (1 << LA_W) - 1;
    localparam int LIM_CAP = (MAX_LOOKAHEAD < LA_MAX) ? MAX_LOOKAHEAD : LA_MAX;

    function automatic logic [MUL_W-1:0] mag_of(input logic signed [REL_W-1:0] v);
        logic signed [MAGX_W-1:0] w;
        w = MAGX_W'(v);
        if (w < 0) begin
            w = -w;
        end
        return MUL_W'(unsigned'(w));
    endfunction

    // input fields
    logic signed [POS_W-1:0] in_own_x;
    logic signed [POS_W-1:0] in_own_y;
    logic signed [HDG_W-1:0] in_own_hdg;
    logic [SPD_W-1:0]        in_own_spd;
    logic signed [POS_W-1:0] in_oth_x;
    logic signed [POS_W-1:0] in_oth_y;
    logic signed [HDG_W-1:0] in_oth_hdg;
    logic [SPD_W-1:0]        in_oth_spd;
    logic [RAD_W-1:0]        in_oth_rad;
    logic [LA_W-1:0]         in_la;

    assign in_own_x   = signed'(s_axis_tdata[31:0]);
    assign in_own_y   = signed'(s_axis_tdata[63:32]);
    assign in_own_hdg = signed'(s_axis_tdata[79:64]);
    assign in_own_spd = s_axis_tdata[111:80];
    assign in_oth_x   = signed'(s_axis_tdata[143:112]);
    assign in_oth_y   = signed'(s_axis_tdata[175:144]);
    assign in_oth_hdg = signed'(s_axis_tdata[191:176]);
    assign in_oth_spd = s_axis_tdata[223:192];
    assign in_oth_rad = s_axis_tdata[255:224];
    assign in_la      = s_axis_tdata[265:256];

    clac_state_t state_reg;
    clac_state_t state_next;
    clac_op_t    op_reg;

    logic [RAD_W-1:0]         own_radius_reg;
    logic [SPD_W-1:0]         own_spd_reg;
    logic [SPD_W-1:0]         oth_spd_reg;
    logic signed [HDG_W-1:0]  oth_hdg_reg;
    logic [LA_W-1:0]          lim_reg;
    logic [RSUM_W-1:0]        rsum_reg;
    logic signed [REL_W-1:0]  rx_reg;
    logic signed [REL_W-1:0]  ry_reg;
    logic signed [CS_W-1:0]   c_own_reg;
    logic signed [CS_W-1:0]   s_own_reg;
    logic signed [CS_W-1:0]   c_oth_reg;
    logic signed [CS_W-1:0]   s_oth_reg;
    logic [MID_W-1:0]         mid_reg;
    logic signed [DISP_W-1:0] odx_reg;
    logic signed [DISP_W-1:0] ody_reg;
    logic signed [DISP_W-1:0] ndx_reg;
    logic signed [DISP_W-1:0] ndy_reg;
    logic signed [DISP_W-1:0] sx_reg;
    logic signed [DISP_W-1:0] sy_reg;
    logic signed [ACC_W-1:0]  r2_reg;
    logic signed [ACC_W-1:0]  d_reg;
    logic signed [ACC_W-1:0]  dl_reg;
    logic signed [ACC_W-1:0]  dd_reg;
    logic [LA_W-1:0]          t_reg;
    logic                     found_reg;
    logic [LA_W-1:0]          step_reg;
    logic                     m_valid_reg;
    logic [M_DATA_W-1:0]      m_data_reg;

    logic                     in_acc;
    logic                     cfg_wr;
    logic [LA_W-1:0]          la_clamped;
    logic signed [POS_W:0]    dx0;
    logic signed [POS_W:0]    dy0;
    logic [RAD_W:0]           rsum_sum;

    cordic_req_t cor_req;
    cordic_rsp_t cor_rsp;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;

    logic                     mul_neg;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [ACC_W-1:0]  prod_sgn;
    logic [QUO_W-1:0]         quo;
    logic signed [DISP_W-1:0] disp_mag;
    logic signed [DISP_W-1:0] disp_val;
    logic                     hit;
    logic                     scan_end;
    logic                     emit_ld;

    clac_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cor_req),
        .rsp     (cor_rsp)
    );

    clac_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_OWN_RADIUS) ? own_radius_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_radius_reg <= OWN_RADIUS_RST;
        end else if (cfg_wr && paddr[2] == REG_OWN_RADIUS) begin
            own_radius_reg <= pwdata;
        end
    end

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign la_clamped = (in_la > LA_W'(LIM_CAP)) ? LA_W'(LIM_CAP) : in_la;
    assign dx0        = (POS_W+1)'(in_oth_x) - (POS_W+1)'(in_own_x);
    assign dy0        = (POS_W+1)'(in_oth_y) - (POS_W+1)'(in_own_y);
    assign rsum_sum   = {1'b0, own_radius_reg} + {1'b0, in_oth_rad};

    // operand select for the shared multiplier
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (op_reg)
            OP_OWN_C: begin
                mul_a = MUL_W'(own_spd_reg);
                mul_b = mag_of(REL_W'(c_own_reg));
            end
            OP_OWN_CQ: begin
                mul_a   = MUL_W'(mid_reg);
                mul_b   = DIV60_RECIP;
                mul_neg = c_own_reg[CS_W-1];
            end
            OP_OWN_S: begin
                mul_a = MUL_W'(own_spd_reg);
                mul_b = mag_of(REL_W'(s_own_reg));
            end
            OP_OWN_SQ: begin
                mul_a   = MUL_W'(mid_reg);
                mul_b   = DIV60_RECIP;
                mul_neg = s_own_reg[CS_W-1];
            end
            OP_OTH_C: begin
                mul_a = MUL_W'(oth_spd_reg);
                mul_b = mag_of(REL_W'(c_oth_reg));
            end
            OP_OTH_CQ: begin
                mul_a   = MUL_W'(mid_reg);
                mul_b   = DIV60_RECIP;
                mul_neg = c_oth_reg[CS_W-1];
            end
            OP_OTH_S: begin
                mul_a = MUL_W'(oth_spd_reg);
                mul_b = mag_of(REL_W'(s_oth_reg));
            end
            OP_OTH_SQ: begin
                mul_a   = MUL_W'(mid_reg);
                mul_b   = DIV60_RECIP;
                mul_neg = s_oth_reg[CS_W-1];
            end
            OP_RAD: begin
                mul_a = MUL_W'(rsum_reg);
                mul_b = MUL_W'(rsum_reg);
            end
            OP_XX: begin
                mul_a = mag_of(rx_reg);
                mul_b = mag_of(rx_reg);
            end
            OP_YY: begin
                mul_a = mag_of(ry_reg);
                mul_b = mag_of(ry_reg);
            end
            OP_XS: begin
                mul_a   = mag_of(rx_reg);
                mul_b   = mag_of(REL_W'(sx_reg));
                mul_neg = rx_reg[REL_W-1] ^ sx_reg[DISP_W-1];
            end
            OP_YS: begin
                mul_a   = mag_of(ry_reg);
                mul_b   = mag_of(REL_W'(sy_reg));
                mul_neg = ry_reg[REL_W-1] ^ sy_reg[DISP_W-1];
            end
            OP_SXX: begin
                mul_a = mag_of(REL_W'(sx_reg));
                mul_b = mag_of(REL_W'(sx_reg));
            end
            OP_SYY: begin
                mul_a = mag_of(REL_W'(sy_reg));
                mul_b = mag_of(REL_W'(sy_reg));
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        prod_acc = signed'(mul_rsp.prod[ACC_W-1:0]);
        prod_sgn = mul_neg ? -prod_acc : prod_acc;
        quo      = mul_rsp.prod[DIV_SHIFT +: QUO_W];
        disp_mag = signed'(DISP_W'(quo));
        disp_val = mul_neg ? -disp_mag : disp_mag;
    end

    assign hit      = (t_reg < lim_reg) && (d_reg < r2_reg);
    assign scan_end = (t_reg >= lim_reg) || hit;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_ROT_OWN;
                end
            end
            ST_ROT_OWN: begin
                if (cor_rsp.done) begin
                    state_next = ST_ROT_OTHER;
                end
            end
            ST_ROT_OTHER: begin
                if (cor_rsp.done) begin
                    state_next = ST_MUL_ISSUE;
                end
            end
            ST_MUL_ISSUE: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    if (op_reg == OP_OTH_SQ) begin
                        state_next = ST_PREP_S;
                    end else if (op_reg == OP_SYY) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_MUL_ISSUE;
                    end
                end
            end
            ST_PREP_S: begin
                state_next = ST_PREP_R;
            end
            ST_PREP_R: begin
                state_next = ST_MUL_ISSUE;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready  = (state_reg == ST_IDLE);
        cor_req.start  = 1'b0;
        cor_req.angle  = oth_hdg_reg;
        mul_req.start  = (state_reg == ST_MUL_ISSUE);
        mul_req.a      = mul_a;
        mul_req.b      = mul_b;
        emit_ld        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cor_req.start = s_axis_tvalid;
                cor_req.angle = in_own_hdg;
            end
            ST_ROT_OWN: begin
                cor_req.start = cor_rsp.done;
            end
            ST_EMIT: begin
                emit_ld = !m_valid_reg || m_axis_tready;
            end
            default: begin
                cor_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_OWN_C;
        end else begin
            state_reg <= state_next;
            if (in_acc) begin
                op_reg <= OP_OWN_C;
            end else if (state_reg == ST_MUL_WAIT && mul_rsp.done) begin
                op_reg <= clac_op_t'(op_reg + 4'd1);
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            own_spd_reg <= in_own_spd;
            oth_spd_reg <= in_oth_spd;
            oth_hdg_reg <= in_oth_hdg;
            lim_reg     <= la_clamped;
            rsum_reg    <= {rsum_sum, 16'b0};
            rx_reg      <= REL_W'(dx0) <<< 16;
            ry_reg      <= REL_W'(dy0) <<< 16;
            t_reg       <= LA_W'(1);
        end
        if (state_reg == ST_ROT_OWN && cor_rsp.done) begin
            c_own_reg <= cor_rsp.cos_val;
            s_own_reg <= cor_rsp.sin_val;
        end
        if (state_reg == ST_ROT_OTHER && cor_rsp.done) begin
            c_oth_reg <= cor_rsp.cos_val;
            s_oth_reg <= cor_rsp.sin_val;
        end
        if (state_reg == ST_MUL_WAIT && mul_rsp.done) begin
            case (op_reg)
                OP_OWN_C, OP_OWN_S, OP_OTH_C, OP_OTH_S: mid_reg <= mul_rsp.prod[MID_W-1:0];
                OP_OWN_CQ: odx_reg <= disp_val;
                OP_OWN_SQ: ody_reg <= disp_val;
                OP_OTH_CQ: ndx_reg <= disp_val;
                OP_OTH_SQ: ndy_reg <= disp_val;
                OP_RAD:    r2_reg  <= prod_acc;
                OP_XX:     d_reg   <= prod_acc;
                OP_YY:     d_reg   <= d_reg + prod_acc;
                OP_XS:     dl_reg  <= prod_sgn <<< 1;
                OP_YS:     dl_reg  <= dl_reg + (prod_sgn <<< 1);
                OP_SXX: begin
                    dl_reg <= dl_reg + prod_acc;
                    dd_reg <= prod_acc <<< 1;
                end
                OP_SYY: begin
                    dl_reg <= dl_reg + prod_acc;
                    dd_reg <= dd_reg + (prod_acc <<< 1);
                end
                default: begin
                    mid_reg <= mid_reg;
                end
            endcase
        end
        if (state_reg == ST_PREP_S) begin
            sx_reg <= ndx_reg - odx_reg;
            sy_reg <= ndy_reg - ody_reg;
        end
        if (state_reg == ST_PREP_R) begin
            rx_reg <= rx_reg + REL_W'(sx_reg);
            ry_reg <= ry_reg + REL_W'(sy_reg);
        end
        if (state_reg == ST_SCAN) begin
            if (scan_end) begin
                found_reg <= hit;
                step_reg  <= hit ? t_reg : '0;
            end else begin
                d_reg  <= d_reg + dl_reg;
                dl_reg <= dl_reg + dd_reg;
                t_reg  <= t_reg + LA_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_ld) begin
            m_data_reg <= M_DATA_W'({step_reg, found_reg});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- hw/rtl/clac_check.sv -----
// ----------------------------------------------------------------------------
// clac_check
// Port-level checks of the collision lookahead check block.
// ----------------------------------------------------------------------------
module clac_check (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [clac_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [clac_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [clac_pkg::APB_ADDR_W-1:0] paddr,
    input logic [clac_pkg::APB_DATA_W-1:0] pwdata,
    input logic [clac_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no hit reports step zero
    a_miss_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[10:1] == 10'd0)
        else $error("step set on a miss");

    // a hit is never at step zero and pad bits stay clear
    a_hit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[10:1] != 10'd0)
                          && m_axis_tdata[15:11] == 5'd0)
        else $error("bad result encoding");

    // a query keeps the block busy for the following cycles
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("query taken while busy");

endmodule

bind collision_lookahead_check clac_check u_clac_check (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-disc constant-velocity collision lookahead.
// Drives query beats on the input stream and collects result beats. Every
// accepted query goes through a bit-exact model: rotation unit, per-step
// displacement and exact 128-bit squared-distance compare. The model result
// is queued and checked field by field against the next result beat. own_radius
// is moved across its range over APB between phases. The stimulus is directed
// corners, then closing encounters and raw random noise. The stream handshakes
// run under several pacing patterns, plus one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import clac_pkg::*;

    localparam int unsigned METRE      = 65536;
    localparam int          HDG_PI     = 25736;
    localparam int          HDG_HALF   = 12868;
    localparam int          N_CORNERS  = 17;
    localparam int          N_SEGMENTS = 6;
    localparam int          SEG_ITEMS  = 95;
    localparam int          HOLD_LEN   = 3000;

    localparam logic [APB_ADDR_W-1:0] ADDR_OWN_RADIUS = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    localparam longint ROT_GAIN    = 39797;
    localparam longint PI_FIX      = 205887;
    localparam longint HALF_PI_FIX = 102944;
    localparam longint STEPS_PER_S = 60;
    localparam int     ROT_ITERS   = 16;
    localparam longint ATAN_STEP [ROT_ITERS] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef enum int {
        PACE_SENDER_SLOW,
        PACE_RECEIVER_SLOW,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [HDG_W-1:0] own_hdg;
        logic [SPD_W-1:0]        own_spd;
        logic signed [POS_W-1:0] oth_x;
        logic signed [POS_W-1:0] oth_y;
        logic signed [HDG_W-1:0] oth_hdg;
        logic [SPD_W-1:0]        oth_spd;
        logic [RAD_W-1:0]        oth_rad;
        logic [LA_W-1:0]         look;
    } query_t;

    typedef struct packed {
        logic            found;
        logic [LA_W-1:0] step;
    } hit_t;

    class hit_scoreboard;
        logic [RAD_W-1:0] own_radius;
        hit_t             expected_hits[$];
        int               errors;
        int               checked;
        int               hits;

        function new();
            own_radius = OWN_RADIUS_RST;
            errors     = 0;
            checked    = 0;
            hits       = 0;
        endfunction

        function void heading_to_unit(input logic signed [HDG_W-1:0] hdg,
                                      output longint c, output longint s);
            longint z, x, y, xs;
            bit     flip;
            z    = longint'(hdg) * 8;
            x    = ROT_GAIN;
            y    = 0;
            flip = 1'b0;
            if (z > HALF_PI_FIX) begin
                z -= PI_FIX;
                flip = 1'b1;
            end else if (z < -HALF_PI_FIX) begin
                z += PI_FIX;
                flip = 1'b1;
            end
            for (int i = 0; i < ROT_ITERS; i++) begin
                xs = x >>> i;
                if (z >= 0) begin
                    x -= y >>> i;
                    y += xs;
                    z -= ATAN_STEP[i];
                end else begin
                    x += y >>> i;
                    y -= xs;
                    z += ATAN_STEP[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // per-step displacement in Q.32 metres
        function void step_motion(input logic [SPD_W-1:0] spd,
                                  input logic signed [HDG_W-1:0] hdg,
                                  output longint dx, output longint dy);
            longint c, s;
            heading_to_unit(hdg, c, s);
            dx = (longint'({32'b0, spd}) * c) / STEPS_PER_S;
            dy = (longint'({32'b0, spd}) * s) / STEPS_PER_S;
        endfunction

        function hit_t first_contact(query_t q);
            longint       odx, ody, ndx, ndy, rx, ry, sx, sy;
            logic [63:0]  rsum, mx, my;
            logic [127:0] reach2, d2;
            int           limit;
            hit_t         r;
            r = '{found: 1'b0, step: '0};
            step_motion(q.own_spd, q.own_hdg, odx, ody);
            step_motion(q.oth_spd, q.oth_hdg, ndx, ndy);
            rx = longint'($signed(q.oth_x)) * 65536 - longint'($signed(q.own_x)) * 65536;
            ry = longint'($signed(q.oth_y)) * 65536 - longint'($signed(q.own_y)) * 65536;
            sx = ndx - odx;
            sy = ndy - ody;
            rsum   = ({32'b0, own_radius} + {32'b0, q.oth_rad}) << 16;
            reach2 = {64'b0, rsum} * {64'b0, rsum};
            limit  = q.look;
            if (limit > MAX_LOOKAHEAD_DEF) limit = MAX_LOOKAHEAD_DEF;
            for (int t = 1; t < limit; t++) begin
                rx += sx;
                ry += sy;
                mx = (rx < 0) ? -rx : rx;
                my = (ry < 0) ? -ry : ry;
                d2 = {64'b0, mx} * {64'b0, mx} + {64'b0, my} * {64'b0, my};
                if (d2 < reach2) begin
                    r.found = 1'b1;
                    r.step  = t[LA_W-1:0];
                    break;
                end
            end
            return r;
        endfunction

        function void note_query(query_t q);
            expected_hits.push_back(first_contact(q));
        endfunction

        function void check_result(logic [M_DATA_W-1:0] beat);
            hit_t            want;
            logic            got_found;
            logic [LA_W-1:0] got_step;
            got_found = beat[0];
            got_step  = beat[LA_W:1];
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual found %0b step %0d",
                         $time, got_found, got_step);
                return;
            end
            want = expected_hits.pop_front();
            checked++;
            if (want.found) hits++;
            if (got_found !== want.found) begin
                errors++;
                $display("%0t: hit_found expected %0b actual %0b", $time, want.found, got_found);
            end
            if (got_step !== want.step) begin
                errors++;
                $display("%0t: hit_step expected %0d actual %0d", $time, want.step, got_step);
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_DATA_W-1:0]     s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]     m_axis_tdata;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr         = '0;
    logic [APB_DATA_W-1:0]   pwdata        = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    hit_scoreboard board = new();
    pace_t         pace  = PACE_SENDER_SLOW;
    int            rx_hold_req = 0;
    int            n_corner, n_encounter, n_noise, n_long, n_radius;

    collision_lookahead_check i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(30_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit sender_waits();
        case (pace)
            PACE_SENDER_SLOW:   return $urandom_range(0, 99) < 37;
            PACE_RECEIVER_SLOW: return $urandom_range(0, 99) < 53;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace)
            PACE_SENDER_SLOW:   return $urandom_range(0, 99) < 53;
            PACE_RECEIVER_SLOW: return $urandom_range(0, 99) < 37;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_query(query_t q);
        logic [S_DATA_W-1:0] d;
        d          = '0;
        d[31:0]    = q.own_x;
        d[63:32]   = q.own_y;
        d[79:64]   = q.own_hdg;
        d[111:80]  = q.own_spd;
        d[143:112] = q.oth_x;
        d[175:144] = q.oth_y;
        d[191:176] = q.oth_hdg;
        d[223:192] = q.oth_spd;
        d[255:224] = q.oth_rad;
        d[265:256] = q.look;
        return d;
    endfunction

    function automatic query_t corner_query(int n);
        query_t q;
        q      = '0;
        q.look = 10'd2;
        case (n)
            0: q.look = 10'd0;
            1: q.look = 10'd1;
            2: q.look = 10'd2;
            3: begin
                q.own_x   = 32'h7FFF_FFFF;
                q.own_y   = 32'h7FFF_FFFF;
                q.oth_x   = 32'h8000_0000;
                q.oth_y   = 32'h8000_0000;
                q.own_spd = '1;
                q.oth_spd = '1;
                q.own_hdg = HDG_PI;
                q.oth_hdg = -HDG_PI;
                q.oth_rad = '1;
                q.look    = 10'd1023;
            end
            4: begin
                q.own_hdg = 16'sh8000;
                q.oth_hdg = 16'sh7FFF;
                q.own_spd = 10 * METRE;
                q.oth_spd = 10 * METRE;
                q.oth_x   = 100 * METRE;
                q.look    = 10'd1023;
            end
            5, 6: begin
                q.own_hdg = (n == 5) ? HDG_HALF : -HDG_HALF;
                q.oth_hdg = (n == 5) ? HDG_HALF + 1 : -HDG_HALF - 1;
                q.own_spd = 5 * METRE;
                q.oth_spd = 5 * METRE;
                q.oth_y   = 50 * METRE;
                q.look    = 10'd400;
            end
            7, 8, 16: begin
                q.own_spd = 10 * METRE;
                q.oth_spd = 10 * METRE;
                q.oth_hdg = HDG_PI;
                q.oth_x   = (n == 16) ? 335 * METRE : 100 * METRE;
                q.look    = (n == 8) ? 10'd200 : 10'd1023;
            end
            9: begin
                q.own_spd = 12 * METRE;
                q.oth_spd = 4 * METRE;
                q.oth_x   = 30 * METRE;
                q.look    = 10'd600;
            end
            10: begin
                q.own_x   = -1000 * METRE;
                q.oth_x   = 1000 * METRE;
                q.oth_rad = '1;
                q.look    = 10'd5;
            end
            11: begin
                q.own_spd = '1;
                q.oth_spd = '1;
                q.oth_x   = METRE / 2;
                q.look    = 10'd3;
            end
            12: begin
                q.own_spd = 8 * METRE;
                q.oth_spd = 8 * METRE;
                q.oth_y   = 5 * METRE;
                q.look    = 10'd1023;
            end
            13: begin
                q.own_x = 32'h8000_0000;
                q.oth_x = 32'h7FFF_FFFF;
                q.look  = 10'd50;
            end
            14: begin
                q.oth_x = 2 * METRE;
                q.look  = 10'd8;
            end
            15: begin
                q.oth_x = 2 * METRE - 1;
                q.look  = 10'd8;
            end
            default: ;
        endcase
        return q;
    endfunction

    // two discs set up to meet near a chosen step, with some miss jitter
    function automatic query_t make_encounter();
        query_t q;
        longint odx, ody, ndx, ndy;
        int     meet;
        q.own_x   = int'($urandom_range(0, 16777215)) - 8388608;
        q.own_y   = int'($urandom_range(0, 16777215)) - 8388608;
        q.own_hdg = int'($urandom_range(0, 2 * HDG_PI)) - HDG_PI;
        q.oth_hdg = int'($urandom_range(0, 2 * HDG_PI)) - HDG_PI;
        q.own_spd = $urandom_range(0, 25 * METRE);
        q.oth_spd = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 25 * METRE);
        q.oth_rad = $urandom_range(0, 4 * METRE);
        q.look    = ($urandom_range(0, 5) == 0) ? 10'd1023 : 10'($urandom_range(2, 160));
        meet      = $urandom_range(1, int'(q.look) + 20);
        board.step_motion(q.own_spd, q.own_hdg, odx, ody);
        board.step_motion(q.oth_spd, q.oth_hdg, ndx, ndy);
        q.oth_x = q.own_x + 32'((-(ndx - odx) * meet) >>> 16)
                + int'($urandom_range(0, 196608)) - 98304;
        q.oth_y = q.own_y + 32'((-(ndy - ody) * meet) >>> 16)
                + int'($urandom_range(0, 196608)) - 98304;
        if (q.look == 10'd1023) n_long++;
        n_encounter++;
        return q;
    endfunction

    function automatic query_t make_noise();
        query_t q;
        q.own_x   = $urandom;
        q.own_y   = $urandom;
        q.own_hdg = $urandom_range(0, 1) ? 16'($urandom)
                                         : 16'(int'($urandom_range(0, 2 * HDG_PI)) - HDG_PI);
        q.own_spd = $urandom;
        q.oth_x   = $urandom;
        q.oth_y   = $urandom;
        q.oth_hdg = $urandom_range(0, 1) ? 16'($urandom)
                                         : 16'(int'($urandom_range(0, 2 * HDG_PI)) - HDG_PI);
        q.oth_spd = $urandom;
        q.oth_rad = $urandom;
        q.look    = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 40));
        n_noise++;
        return q;
    endfunction

    task automatic send_query(input query_t q);
        while (sender_waits()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_query(q);
        do @(posedge aclk); while (!s_axis_tready);
        board.note_query(q);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_OWN_RADIUS) begin
            board.own_radius = value;
            n_radius++;
        end
        @(posedge aclk);
    endtask

    task automatic radius_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_OWN_RADIUS;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== board.own_radius) begin
            board.errors++;
            $display("%0t: own_radius readback expected %0h actual %0h",
                     $time, board.own_radius, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // result side, with an optional long hold-off
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !receiver_stalls();
            end
        end
    end

    initial begin
        logic [RAD_W-1:0] seg_radius;
        query_t           q;
        n_corner    = 0;
        n_encounter = 0;
        n_noise     = 0;
        n_long      = 0;
        n_radius    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        radius_readback();
        pace = PACE_SENDER_SLOW;
        for (int n = 0; n < N_CORNERS; n++) begin
            send_query(corner_query(n));
            n_corner++;
        end
        drain();

        // zero total radius never hits, even on top of each other, while a tiny other radius does
        reg_write(ADDR_OWN_RADIUS, '0);
        radius_readback();
        q      = '0;
        q.look = 10'd10;
        send_query(q);
        q.oth_rad = 32'd1;
        send_query(q);
        n_corner += 2;
        drain();

        reg_write(ADDR_UNMAPPED, $urandom);
        radius_readback();

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            pace = pace_t'(seg / 2);
            case (seg)
                0:       seg_radius = '1;
                1:       seg_radius = 2 * METRE;
                2:       seg_radius = $urandom;
                3:       seg_radius = $urandom_range(0, 6 * METRE);
                4:       seg_radius = METRE;
                default: seg_radius = '0;
            endcase
            reg_write(ADDR_OWN_RADIUS, seg_radius);
            radius_readback();
            if (seg == 4) rx_hold_req = HOLD_LEN;
            repeat (SEG_ITEMS) begin
                if ($urandom_range(0, 9) < 7) send_query(make_encounter());
                else send_query(make_noise());
            end
            drain();
        end

        repeat (1200) @(posedge aclk);
        board.errors += board.pending();
        $display("covered %0d corner, %0d encounter (%0d full horizon), %0d noise queries",
                 n_corner, n_encounter, n_long, n_noise);
        $display("%0d results checked, %0d hits, %0d own_radius settings",
                 board.checked, board.hits, n_radius);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/clac_pkg.sv
hw/rtl/clac_cordic.sv
hw/rtl/clac_mul.sv
hw/rtl/collision_lookahead_check.sv
hw/rtl/clac_check.sv
test/tb.sv
